// ----- rtl/sprite_catalog_parser_defines.svh -----
// Assertion macros used by the parse core of the sprite catalog parser.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef SPRITE_CATALOG_PARSER_DEFINES_SVH
`define SPRITE_CATALOG_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCP_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCP_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/scp_pkg.sv -----
// Types and constants of the sprite catalog parser.
// No dependencies; the stage modules and the top level refer to it by scoped names.
package scp_pkg;

  localparam logic [2:0] StEntry     = 3'd0;
  localparam logic [2:0] StFinal     = 3'd1;
  localparam logic [2:0] StBadMagic  = 3'd2;
  localparam logic [2:0] StZeroCount = 3'd3;
  localparam logic [2:0] StTruncated = 3'd4;

  localparam logic [31:0] CatMagic    = 32'hFFFF_FFFE;
  localparam logic [5:0]  HdrLastPos  = 6'd11;
  localparam logic [5:0]  BodyLastPos = 6'd32;
  localparam int unsigned NumFields   = 8;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       end_of_data;
  } beat_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [31:0] entry_index;
    logic [31:0] atlas_x;
    logic [31:0] atlas_y;
    logic [31:0] sprite_width;
    logic [31:0] sprite_height;
    logic [31:0] offset_x;
    logic [31:0] offset_y;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
    logic [7:0]  entry_flag;
    logic [31:0] pixel_depth;
  } result_t;

endpackage

// ----- rtl/scp_if.sv -----
// Valid/ready channel interfaces for the catalog byte stream and the results.
// Depends on nothing; used by the top level and its stages.
interface scp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface scp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] entry_index;
  logic [31:0] atlas_x;
  logic [31:0] atlas_y;
  logic [31:0] sprite_width;
  logic [31:0] sprite_height;
  logic [31:0] offset_x;
  logic [31:0] offset_y;
  logic [31:0] frame_width;
  logic [31:0] frame_height;
  logic [7:0]  entry_flag;
  logic [31:0] pixel_depth;

  modport source (
    output valid, output status, output entry_index, output atlas_x, output atlas_y,
    output sprite_width, output sprite_height, output offset_x, output offset_y,
    output frame_width, output frame_height, output entry_flag, output pixel_depth,
    input ready
  );
  modport sink (
    input valid, input status, input entry_index, input atlas_x, input atlas_y,
    input sprite_width, input sprite_height, input offset_x, input offset_y,
    input frame_width, input frame_height, input entry_flag, input pixel_depth,
    output ready
  );
endinterface

// ----- rtl/scp_in_stage.sv -----
// Input register of the sprite catalog parser: holds one byte beat for parsing.
// Depends on scp_pkg and scp_in_if.
module scp_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  scp_in_if.sink          in_i,
  input  logic            adv_i,
  output scp_pkg::beat_t  beat_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       eod_q;
  logic       take;

  assign in_i.ready = !vld_q || adv_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (in_i.ready) begin
      vld_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= in_i.data_byte;
      eod_q  <= in_i.end_of_data;
    end
  end

  assign beat_o.valid       = vld_q;
  assign beat_o.data_byte   = byte_q;
  assign beat_o.end_of_data = eod_q;

endmodule

// ----- rtl/scp_parse_core.sv -----
// Parse state of the sprite catalog parser: header, name, padding and field
// decoding for one byte per step. Depends on scp_pkg and the defines header.
`include "sprite_catalog_parser_defines.svh"

module scp_parse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scp_pkg::beat_t    beat_i,
  input  logic              adv_i,
  output scp_pkg::result_t  res_o
);

  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhName    = 3'd1;
  localparam logic [2:0] PhPad     = 3'd2;
  localparam logic [2:0] PhFields  = 3'd3;
  localparam logic [2:0] PhNext    = 3'd4;
  localparam logic [2:0] PhDone    = 3'd5;
  localparam logic [2:0] PhErrWait = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [1:0]  pad_q, pad_d;
  logic [31:0] total_q, total_d;
  logic [31:0] depth_q, depth_d;
  logic [31:0] idx_q, idx_d;
  logic [31:0] ws_q, ws_d;
  logic [31:0] fields_q [scp_pkg::NumFields];

  logic        step;
  logic [31:0] val;
  logic [5:0]  pos_inc;
  logic [1:0]  pad_inc;
  logic        fld_we;
  logic        emit;
  logic [2:0]  emit_st;
  logic        err_vld;
  logic [2:0]  err_st;
  logic        waiting;

  assign step    = beat_i.valid && adv_i;
  assign val     = {24'd0, beat_i.data_byte} << {pos_q[1:0], 3'b000};
  assign pos_inc = pos_q + 6'd1;
  assign pad_inc = pad_q + 2'd1;
  assign waiting = phase_q > PhNext;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    pad_d   = pad_q;
    total_d = total_q;
    depth_d = depth_q;
    idx_d   = idx_q;
    ws_d    = ws_q;
    fld_we  = 1'b0;
    emit    = 1'b0;
    emit_st = scp_pkg::StEntry;
    err_vld = 1'b0;
    err_st  = scp_pkg::StEntry;

    unique case (phase_q)
      PhHeader: begin
        if (pos_q < 6'd4) begin
          ws_d = (pos_q == 6'd0) ? val : (ws_q | val);
        end else if (pos_q < 6'd8) begin
          total_d = (pos_q == 6'd4) ? val : (total_q | val);
        end else begin
          depth_d = (pos_q == 6'd8) ? val : (depth_q | val);
        end
        if (pos_q >= scp_pkg::HdrLastPos) begin
          if (ws_d != scp_pkg::CatMagic) begin
            err_vld = 1'b1;
            err_st  = scp_pkg::StBadMagic;
          end else if (total_d == 32'd0) begin
            err_vld = 1'b1;
            err_st  = scp_pkg::StZeroCount;
          end else begin
            idx_d   = 32'd0;
            phase_d = PhName;
            pad_d   = 2'd0;
            pos_d   = 6'd0;
          end
        end else begin
          pos_d = pos_inc;
        end
      end
      PhName: begin
        pad_d = pad_inc;
        if (beat_i.data_byte == 8'd0) begin
          pos_d   = 6'd0;
          phase_d = (pad_inc == 2'd0) ? PhFields : PhPad;
        end
      end
      PhPad: begin
        pad_d = pad_inc;
        if (pad_inc == 2'd0) begin
          phase_d = PhFields;
          pos_d   = 6'd0;
        end
      end
      PhFields: begin
        if (pos_q < scp_pkg::BodyLastPos) begin
          ws_d   = (pos_q[1:0] == 2'd0) ? val : (ws_q | val);
          fld_we = (pos_q[1:0] == 2'd3);
          pos_d  = pos_inc;
        end else begin
          ws_d = {24'd0, beat_i.data_byte};
          if (idx_q == total_q - 32'd1) begin
            emit    = 1'b1;
            emit_st = scp_pkg::StFinal;
            phase_d = PhDone;
          end else begin
            phase_d = PhNext;
            pos_d   = 6'd0;
          end
        end
      end
      PhNext: begin
        pos_d = pos_inc;
        if (pos_inc >= 6'd4) begin
          emit    = 1'b1;
          emit_st = scp_pkg::StEntry;
          idx_d   = idx_q + 32'd1;
          phase_d = PhName;
          pad_d   = 2'd0;
          pos_d   = 6'd0;
        end
      end
      default: begin
      end
    endcase

    if (!waiting && !err_vld && beat_i.end_of_data && phase_d != PhDone) begin
      err_vld = 1'b1;
      err_st  = scp_pkg::StTruncated;
    end
    if (err_vld) begin
      phase_d = PhErrWait;
    end
    if (beat_i.end_of_data) begin
      phase_d = PhHeader;
      pos_d   = 6'd0;
      pad_d   = 2'd0;
      idx_d   = 32'd0;
    end
  end

  always_comb begin
    res_o = '0;
    res_o.valid = emit || err_vld;
    if (err_vld) begin
      res_o.status = err_st;
    end else begin
      res_o.status        = emit_st;
      res_o.entry_index   = idx_q;
      res_o.atlas_x       = fields_q[0];
      res_o.atlas_y       = fields_q[1];
      res_o.sprite_width  = fields_q[2];
      res_o.sprite_height = fields_q[3];
      res_o.offset_x      = fields_q[4];
      res_o.offset_y      = fields_q[5];
      res_o.frame_width   = fields_q[6];
      res_o.frame_height  = fields_q[7];
      res_o.entry_flag    = ws_d[7:0];
      res_o.pixel_depth   = depth_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q   <= 6'd0;
      pad_q   <= 2'd0;
      total_q <= 32'd0;
      depth_q <= 32'd0;
      idx_q   <= 32'd0;
      ws_q    <= 32'd0;
    end else if (step) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      pad_q   <= pad_d;
      total_q <= total_d;
      depth_q <= depth_d;
      idx_q   <= idx_d;
      ws_q    <= ws_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && fld_we) begin
      fields_q[pos_q[4:2]] <= ws_d;
    end
  end

  `SCP_ASSERT_NEXT(a_eod_rearms, step && beat_i.end_of_data, phase_q == PhHeader && idx_q == 32'd0, "End-of-data beat did not re-arm the parser.")
  `SCP_ASSERT_NOW(a_wait_silent, step && (phase_q == PhDone || phase_q == PhErrWait), !res_o.valid, "A waiting state produced a result.")
  `SCP_ASSERT_NOW(a_fields_aligned, phase_q == PhFields && $past(phase_q) != PhFields, pad_q == 2'd0 && pos_q == 6'd0, "Field decoding started off a 4-byte name boundary.")

endmodule

// ----- rtl/scp_out_stage.sv -----
// Result register of the sprite catalog parser: holds one result beat until taken.
// Depends on scp_pkg and scp_out_if.
module scp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scp_pkg::result_t  res_i,
  input  logic              step_i,
  output logic              adv_o,
  scp_out_if.source         out_o
);

  logic              vld_q, vld_d;
  scp_pkg::result_t  res_q;

  assign adv_o = !vld_q || out_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (adv_o) begin
      vld_d = step_i && res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && res_i.valid) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = vld_q;
  assign out_o.status        = res_q.status;
  assign out_o.entry_index   = res_q.entry_index;
  assign out_o.atlas_x       = res_q.atlas_x;
  assign out_o.atlas_y       = res_q.atlas_y;
  assign out_o.sprite_width  = res_q.sprite_width;
  assign out_o.sprite_height = res_q.sprite_height;
  assign out_o.offset_x      = res_q.offset_x;
  assign out_o.offset_y      = res_q.offset_y;
  assign out_o.frame_width   = res_q.frame_width;
  assign out_o.frame_height  = res_q.frame_height;
  assign out_o.entry_flag    = res_q.entry_flag;
  assign out_o.pixel_depth   = res_q.pixel_depth;

endmodule

// ----- rtl/sprite_catalog_parser.sv -----
// Sprite catalog parser top level: input register, parse core, result register.
// Depends on scp_pkg, scp_if, scp_in_stage, scp_parse_core and scp_out_stage.
//
// The parser takes one catalog byte per cycle while the result side keeps
// taking beats, and produces at most one result beat per byte: an entry record
// after the last byte of its next-name size (or after the flag byte of the final
// entry), or a single error beat for bad magic, zero count or early end of data.
// A byte is held in the input register, and its result is captured into the
// result register, from which it is offered until taken. The rate is set by the
// parse state update, which consumes one byte per cycle in which it advances.
// After an error, and after the final entry, bytes are swallowed until a beat
// with end_of_data set, which always returns the parser to the header.
module sprite_catalog_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  scp_in_if.sink      in_i,
  scp_out_if.source   out_o
);

  scp_pkg::beat_t    beat;
  scp_pkg::result_t  res;
  logic              adv;
  logic              step;

  assign step = beat.valid && adv;

  scp_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (adv),
    .beat_o (beat)
  );

  scp_parse_core u_parse_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .adv_i  (adv),
    .res_o  (res)
  );

  scp_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .step_i (step),
    .adv_o  (adv),
    .out_o  (out_o)
  );

endmodule
